/* hw/rtl/pfp_pkg.sv */
// ----------------------------------------------------------------------------
// pfp_pkg: shared definitions for the preamble frame parser
// Sizes, register indexes, verdict codes and the structs passed between the
// parser core and the top level.
// ----------------------------------------------------------------------------
package pfp_pkg;

  // Receive buffer size; the largest payload a frame may declare follows from it.
  localparam int BUFFER_BYTES = 256;
  localparam int MAX_PAYLOAD  = BUFFER_BYTES - 11;
  localparam int LEN_W        = $clog2(MAX_PAYLOAD + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_CMD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VER_CMD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_MINLEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VER_MINLEN  = 3'd4;

  // Configuration reset values
  localparam logic [7:0] RST_PREAMBLE    = 8'hAA;
  localparam logic [7:0] RST_DIST_CMD    = 8'd2;
  localparam logic [7:0] RST_VER_CMD     = 8'd10;
  localparam logic [7:0] RST_DIST_MINLEN = 8'd195;
  localparam logic [7:0] RST_VER_MINLEN  = 8'd4;

  // Number of preamble bytes that open a frame
  localparam int PREAMBLE_COUNT = 4;

  // Result item kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERDICT_BAD_SUM  = 2'd0;
  localparam logic [1:0] VERDICT_DISTANCE = 2'd1;
  localparam logic [1:0] VERDICT_VERSION  = 2'd2;
  localparam logic [1:0] VERDICT_IGNORED  = 2'd3;

  typedef struct packed {
    logic [7:0] preamble_byte;
    logic [7:0] distance_command;
    logic [7:0] version_command;
    logic [7:0] distance_min_length;
    logic [7:0] version_min_length;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       item_kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [1:0] verdict;
    logic [7:0] frame_command;
    logic [7:0] payload_length;
  } result_t;

  // Fits a length-sized value into an 8-bit output field
  function automatic logic [7:0] to_byte(input logic [LEN_W-1:0] x);
    logic [LEN_W+7:0] t;
    t = {8'b0, x};
    return t[7:0];
  endfunction

endpackage

/* hw/rtl/pfp_if.sv */
// ----------------------------------------------------------------------------
// pfp_if: stream channels of the preamble frame parser
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface pfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfp_res_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [1:0] verdict;
  logic [7:0] frame_command;
  logic [7:0] payload_length;

  modport source (output valid, output item_kind, output data_byte, output byte_index,
                  output verdict, output frame_command, output payload_length,
                  input ready);
  modport sink   (input valid, input item_kind, input data_byte, input byte_index,
                  input verdict, input frame_command, input payload_length,
                  output ready);
endinterface

/* hw/rtl/preamble_frame_parser_sum8.sv */
// ----------------------------------------------------------------------------
// preamble_frame_parser_sum8: preamble framed packet parser, 8-bit sum check
//
// Received bytes arrive on the rx channel, one per transfer. The parser hunts
// for four preamble bytes, reads the address, command, offset and 16-bit
// little-endian length, then forwards each payload byte as a result transfer
// tagged with its index. At the checksum byte it gives one verdict transfer.
// Frames declaring a length above the buffer limit are dropped silently.
// Each rx transfer causes at most one result transfer, which appears on the
// res channel the cycle after the byte is taken. The block takes one byte
// every cycle unless stalled; the single result register is the only storage
// between the two channels, and it is refilled in the same cycle it is
// emptied. When the receiver stalls, the result register holds and rx ready
// drops until it is taken. Registers are written via cfg_we, cfg_index and
// cfg_data; the user must write them only while the block is idle, which the
// block does not enforce. Synchronous reset returns the parser to hunting,
// clears the running sum and the result register, and restores the defaults.
// ----------------------------------------------------------------------------
module preamble_frame_parser_sum8 (
  input  logic                          clk,
  input  logic                          rst,
  pfp_rx_if.sink                        rx,
  pfp_res_if.source                     res,
  input  logic                          cfg_we,
  input  logic [pfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import pfp_pkg::*;

  cfg_t    cfg;
  result_t result;
  logic    step;
  logic    res_valid;
  result_t res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_byte       <= RST_PREAMBLE;
      cfg.distance_command    <= RST_DIST_CMD;
      cfg.version_command     <= RST_VER_CMD;
      cfg.distance_min_length <= RST_DIST_MINLEN;
      cfg.version_min_length  <= RST_VER_MINLEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PREAMBLE:    cfg.preamble_byte       <= cfg_data;
        CFG_DIST_CMD:    cfg.distance_command    <= cfg_data;
        CFG_VER_CMD:     cfg.version_command     <= cfg_data;
        CFG_DIST_MINLEN: cfg.distance_min_length <= cfg_data;
        CFG_VER_MINLEN:  cfg.version_min_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A byte is taken whenever the result register is empty or being emptied.
  assign rx.ready = !res_valid || res.ready;
  assign step     = rx.valid && rx.ready;

  pfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx.ready) begin
      res_valid <= step && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      res_data <= result;
    end
  end

  assign res.valid          = res_valid;
  assign res.item_kind      = res_data.item_kind;
  assign res.data_byte      = res_data.data_byte;
  assign res.byte_index     = res_data.byte_index;
  assign res.verdict        = res_data.verdict;
  assign res.frame_command  = res_data.frame_command;
  assign res.payload_length = res_data.payload_length;

endmodule

/* hw/rtl/pfp_parser.sv */
// ----------------------------------------------------------------------------
// pfp_parser: frame state machine and checksum
// Advances the frame state by one received byte whenever step is high and
// presents the result, if any, that the byte causes in the same cycle.
// ----------------------------------------------------------------------------
module pfp_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  input  pfp_pkg::cfg_t   cfg,
  output pfp_pkg::result_t result
);
  import pfp_pkg::*;

  localparam logic [3:0] PH_WAIT    = 4'd0;
  localparam logic [3:0] PH_RUN     = 4'd1;
  localparam logic [3:0] PH_ADDR    = 4'd2;
  localparam logic [3:0] PH_CMD     = 4'd3;
  localparam logic [3:0] PH_OFF_LO  = 4'd4;
  localparam logic [3:0] PH_OFF_HI  = 4'd5;
  localparam logic [3:0] PH_LEN_LO  = 4'd6;
  localparam logic [3:0] PH_LEN_HI  = 4'd7;
  localparam logic [3:0] PH_PAYLOAD = 4'd8;
  localparam logic [3:0] PH_CHECK   = 4'd9;

  localparam logic [2:0]  RUN_LAST = 3'(PREAMBLE_COUNT - 1);
  localparam logic [15:0] LEN_MAX  = 16'(MAX_PAYLOAD);

  logic [3:0]       phase, phase_next;
  logic [2:0]       preamble_run, preamble_run_next;
  logic [7:0]       frame_cmd, frame_cmd_next;
  logic [7:0]       len_lo, len_lo_next;
  logic [LEN_W-1:0] frame_len, frame_len_next;
  logic [LEN_W-1:0] payload_count, payload_count_next;
  logic [7:0]       running_sum, running_sum_next;

  logic [7:0]       sum_add;
  logic [15:0]      len_full;
  logic [LEN_W:0]   count_inc;
  logic [1:0]       verdict_code;

  assign sum_add   = running_sum + rx_byte;
  assign len_full  = {rx_byte, len_lo};
  assign count_inc = {1'b0, payload_count} + 1'b1;

  // A distance match takes priority when both command codes are equal.
  always_comb begin
    if (running_sum != rx_byte) begin
      verdict_code = VERDICT_BAD_SUM;
    end else if (frame_cmd == cfg.distance_command) begin
      verdict_code = (16'(frame_len) >= 16'(cfg.distance_min_length)) ?
                     VERDICT_DISTANCE : VERDICT_IGNORED;
    end else if (frame_cmd == cfg.version_command) begin
      verdict_code = (16'(frame_len) >= 16'(cfg.version_min_length)) ?
                     VERDICT_VERSION : VERDICT_IGNORED;
    end else begin
      verdict_code = VERDICT_IGNORED;
    end
  end

  always_comb begin
    phase_next         = phase;
    preamble_run_next  = preamble_run;
    frame_cmd_next     = frame_cmd;
    len_lo_next        = len_lo;
    frame_len_next     = frame_len;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;

    result.valid          = 1'b0;
    result.item_kind      = KIND_PAYLOAD;
    result.data_byte      = 8'd0;
    result.byte_index     = 8'd0;
    result.verdict        = VERDICT_BAD_SUM;
    result.frame_command  = frame_cmd;
    result.payload_length = to_byte(frame_len);

    unique case (phase)
      PH_WAIT: begin
        if (rx_byte == cfg.preamble_byte) begin
          preamble_run_next = 3'd1;
          phase_next        = PH_RUN;
        end
      end
      PH_RUN: begin
        // A broken run drops back to hunting without re-examining the byte.
        if (rx_byte == cfg.preamble_byte) begin
          preamble_run_next = preamble_run + 3'd1;
          if (preamble_run >= RUN_LAST) begin
            phase_next = PH_ADDR;
          end
        end else begin
          phase_next = PH_WAIT;
        end
      end
      PH_ADDR: begin
        running_sum_next = rx_byte;
        phase_next       = PH_CMD;
      end
      PH_CMD: begin
        frame_cmd_next   = rx_byte;
        running_sum_next = sum_add;
        phase_next       = PH_OFF_LO;
      end
      PH_OFF_LO: begin
        running_sum_next = sum_add;
        phase_next       = PH_OFF_HI;
      end
      PH_OFF_HI: begin
        running_sum_next = sum_add;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        running_sum_next = sum_add;
        len_lo_next      = rx_byte;
        phase_next       = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        running_sum_next   = sum_add;
        payload_count_next = '0;
        frame_len_next     = len_full[LEN_W-1:0];
        if (len_full > LEN_MAX) begin
          phase_next        = PH_WAIT;
          preamble_run_next = 3'd0;
          frame_len_next    = '0;
        end else if (len_full == 16'd0) begin
          phase_next = PH_CHECK;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next   = sum_add;
        result.valid       = 1'b1;
        result.data_byte   = rx_byte;
        result.byte_index  = to_byte(payload_count);
        payload_count_next = count_inc[LEN_W-1:0];
        if (count_inc >= {1'b0, frame_len}) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        result.valid       = 1'b1;
        result.item_kind   = KIND_VERDICT;
        result.verdict     = verdict_code;
        phase_next         = PH_WAIT;
        preamble_run_next  = 3'd0;
        frame_len_next     = '0;
        payload_count_next = '0;
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      preamble_run  <= 3'd0;
      frame_cmd     <= 8'd0;
      len_lo        <= 8'd0;
      frame_len     <= '0;
      payload_count <= '0;
      running_sum   <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      preamble_run  <= preamble_run_next;
      frame_cmd     <= frame_cmd_next;
      len_lo        <= len_lo_next;
      frame_len     <= frame_len_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
    end
  end

endmodule

/* tb/preamble_frame_parser_sum8_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// preamble_frame_parser_sum8_tb: self-checking bench for the frame parser
// Drives received bytes through the rx channel and compares every result
// transfer with a cycle-free model of the parser kept in this module. A short
// hand-written byte table comes first, then random frames under several
// register settings and three idling patterns, with one long receiver stall.
// ----------------------------------------------------------------------------
module preamble_frame_parser_sum8_tb;
  import pfp_pkg::*;

  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int N_DIRECTED     = 35;
  localparam int N_REG_SETS     = 5;

  typedef enum logic [3:0] {
    HUNT, PREAMBLE, ADDR, CMD, OFF_LO, OFF_HI, LEN_LO, LEN_HI, PAYLOAD, CHECKSUM
  } parse_phase_e;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [1:0] verdict;
    logic [7:0] frame_command;
    logic [7:0] payload_length;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    rx_byte;
    logic          has_want;
    frame_result_t want;
  } stim_row_t;

  localparam frame_result_t NO_RESULT = '0;

  // Hand-written opening: a short version reply, a broken preamble, an
  // oversized frame and an empty frame with a wrong checksum.
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{8'hAA, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT}, '{8'h0A, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, 8'h00, '0, 8'h0A, 8'h01}},
    '{8'h0B, 1'b1, '{KIND_VERDICT, 8'h00, 8'h00, VERDICT_IGNORED, 8'h0A, 8'h01}},
    '{8'hAA, 1'b0, NO_RESULT}, '{8'h55, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h02, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'hF6, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{KIND_VERDICT, 8'h00, 8'h00, VERDICT_BAD_SUM, 8'hFF, 8'h00}}
  };

  // Register settings for the random phases: extremes, equal command codes,
  // largest minimum lengths and a command code equal to the preamble byte.
  localparam cfg_t REG_SETS [N_REG_SETS] = '{
    '{8'h00, 8'h00, 8'hFF, 8'd0,   8'd245},
    '{8'hFF, 8'h55, 8'h55, 8'd3,   8'd0},
    '{8'h5A, 8'h81, 8'h7E, 8'd12,  8'd1},
    '{8'hAA, 8'h02, 8'h0A, 8'd245, 8'd245},
    '{8'h3C, 8'hC3, 8'h3C, 8'd6,   8'd9}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  pfp_rx_if  rx_ch ();
  pfp_res_if res_ch ();

  preamble_frame_parser_sum8 dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Parser model state and the register values it is judged against
  cfg_t          cfg_shadow;
  parse_phase_e  pred_phase;
  logic [2:0]    pred_run;
  logic [7:0]    pred_cmd;
  logic [15:0]   pred_len;
  logic [15:0]   pred_count;
  logic [7:0]    pred_sum;

  frame_result_t awaited_results [$];
  stim_row_t     typed_answer_q [$];
  int unsigned   sent_count;
  int unsigned   taken_count;
  int unsigned   fail_count;
  int unsigned   quiet_cycles;
  int unsigned   tx_gap_pct;
  int unsigned   rx_stall_pct;
  bit            hold_off_start;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void restart_hunt();
    pred_phase = HUNT;
    pred_run   = '0;
    pred_len   = '0;
    pred_count = '0;
  endfunction

  // Advances the model by one received byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, output frame_result_t r);
    bit         hit;
    logic [1:0] v;
    hit = 1'b0;
    r   = NO_RESULT;
    case (pred_phase)
      HUNT: begin
        if (b == cfg_shadow.preamble_byte) begin
          pred_run   = 3'd1;
          pred_phase = PREAMBLE;
        end
      end
      PREAMBLE: begin
        if (b == cfg_shadow.preamble_byte) begin
          pred_run = pred_run + 3'd1;
          if (pred_run >= PREAMBLE_COUNT) pred_phase = ADDR;
        end else begin
          pred_phase = HUNT;
        end
      end
      ADDR: begin
        pred_sum   = b;
        pred_phase = CMD;
      end
      CMD: begin
        pred_cmd   = b;
        pred_sum   = pred_sum + b;
        pred_phase = OFF_LO;
      end
      OFF_LO: begin
        pred_sum   = pred_sum + b;
        pred_phase = OFF_HI;
      end
      OFF_HI: begin
        pred_sum   = pred_sum + b;
        pred_phase = LEN_LO;
      end
      LEN_LO: begin
        pred_sum   = pred_sum + b;
        pred_len   = {8'h00, b};
        pred_phase = LEN_HI;
      end
      LEN_HI: begin
        pred_sum        = pred_sum + b;
        pred_len[15:8]  = b;
        pred_count      = '0;
        if (pred_len > MAX_PAYLOAD) restart_hunt();
        else if (pred_len == 16'd0) pred_phase = CHECKSUM;
        else pred_phase = PAYLOAD;
      end
      PAYLOAD: begin
        pred_sum = pred_sum + b;
        r   = '{KIND_PAYLOAD, b, pred_count[7:0], '0, pred_cmd, pred_len[7:0]};
        hit = 1'b1;
        pred_count = pred_count + 16'd1;
        if (pred_count >= pred_len) pred_phase = CHECKSUM;
      end
      CHECKSUM: begin
        // A distance match wins when both command codes are the same.
        if (pred_sum != b) begin
          v = VERDICT_BAD_SUM;
        end else if (pred_cmd == cfg_shadow.distance_command) begin
          v = (pred_len >= cfg_shadow.distance_min_length) ? VERDICT_DISTANCE
                                                           : VERDICT_IGNORED;
        end else if (pred_cmd == cfg_shadow.version_command) begin
          v = (pred_len >= cfg_shadow.version_min_length) ? VERDICT_VERSION
                                                          : VERDICT_IGNORED;
        end else begin
          v = VERDICT_IGNORED;
        end
        r   = '{KIND_VERDICT, 8'h00, 8'h00, v, pred_cmd, pred_len[7:0]};
        hit = 1'b1;
        restart_hunt();
      end
      default: pred_phase = HUNT;
    endcase
    return hit;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Both channels are sampled at the clock edge; the model moves on each
  // accepted byte and each result transfer is matched with the oldest entry.
  always @(posedge clk) begin : monitor
    stim_row_t     note;
    frame_result_t predicted;
    frame_result_t got;
    frame_result_t want;
    bit            produced;
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready) begin
        note     = typed_answer_q.pop_front();
        produced = parse_byte(rx_ch.rx_byte, predicted);
        if (note.has_want) awaited_results.push_back(note.want);
        else if (produced) awaited_results.push_back(predicted);
        taken_count++;
      end
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.item_kind, res_ch.data_byte, res_ch.byte_index, res_ch.verdict,
                res_ch.frame_command, res_ch.payload_length};
        if (awaited_results.size() == 0) begin
          $error("unexpected result transfer: kind %0d data %0h verdict %0d",
                 got.item_kind, got.data_byte, got.verdict);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("item_kind", 32'(want.item_kind), 32'(got.item_kind));
          check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
          check_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
          check_field("verdict", 32'(want.verdict), 32'(got.verdict));
          check_field("frame_command", 32'(want.frame_command),
                      32'(got.frame_command));
          check_field("payload_length", 32'(want.payload_length),
                      32'(got.payload_length));
        end
      end
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int unsigned hold_left;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_start) begin
        hold_off_start = 1'b0;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offers one byte and returns at the edge of its transfer, once the
  // model has taken it in.
  task automatic send_row(input stim_row_t row);
    while ($urandom_range(99) < tx_gap_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    typed_answer_q.push_back(row);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= row.rx_byte;
    sent_count++;
    do @(posedge clk); while (!rx_ch.ready);
    wait (taken_count == sent_count);
  endtask

  task automatic send_raw(input logic [7:0] b);
    send_row('{b, 1'b0, NO_RESULT});
  endtask

  task automatic send_frame(input int unsigned len, input logic [7:0] cmd,
                            input bit good_sum);
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [15:0] len16;
    len16 = len[15:0];
    repeat (PREAMBLE_COUNT) send_raw(cfg_shadow.preamble_byte);
    b = 8'($urandom);
    send_raw(b);
    sum = b;
    send_raw(cmd);
    sum = sum + cmd;
    repeat (2) begin
      b = 8'($urandom);
      send_raw(b);
      sum = sum + b;
    end
    send_raw(len16[7:0]);
    send_raw(len16[15:8]);
    sum = sum + len16[7:0] + len16[15:8];
    // An oversized length ends the frame silently, so nothing more is sent.
    if (len16 <= MAX_PAYLOAD) begin
      for (int unsigned i = 0; i < len; i++) begin
        b = 8'($urandom);
        send_raw(b);
        sum = sum + b;
      end
      send_raw(good_sum ? sum : sum ^ 8'($urandom_range(255, 1)));
    end
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned min_len;
    logic [7:0]  cmd;
    logic [7:0]  b;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(4, 1)) begin
        b = 8'($urandom);
        send_raw(b);
      end
    end
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(3, 1)) send_raw(cfg_shadow.preamble_byte);
      send_raw(cfg_shadow.preamble_byte + 8'($urandom_range(255, 1)));
    end else begin
      pick = $urandom_range(99);
      if (pick < 40) cmd = cfg_shadow.distance_command;
      else if (pick < 80) cmd = cfg_shadow.version_command;
      else cmd = 8'($urandom);
      if (cmd == cfg_shadow.distance_command) begin
        min_len = 32'(cfg_shadow.distance_min_length);
      end else if (cmd == cfg_shadow.version_command) begin
        min_len = 32'(cfg_shadow.version_min_length);
      end else begin
        min_len = 4;
      end
      // Mostly short payloads; lengths near the minimum only where cheap.
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = $urandom_range(10, 0);
      end else if (pick < 75 && min_len <= 40) begin
        len = $urandom_range(min_len + 1, (min_len == 0) ? 0 : min_len - 1);
      end else if (pick < 88) begin
        if ($urandom_range(1)) len = $urandom_range(300, MAX_PAYLOAD + 1);
        else len = ($urandom_range(255, 1) << 8) | $urandom_range(255);
      end else begin
        len = $urandom_range(40, 11);
      end
      send_frame(len, cmd, $urandom_range(99) < 80);
    end
  endtask

  // Brings the parser back to hunting and lets every result drain.
  task automatic quiesce();
    while (pred_phase != HUNT) send_raw(cfg_shadow.preamble_byte ^ 8'h01);
    rx_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned start;
    start = sent_count;
    while (sent_count - start < budget) send_random_frame();
    quiesce();
  endtask

  task automatic load_settings(input cfg_t s);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PREAMBLE;
    cfg_data  <= s.preamble_byte;
    @(posedge clk);
    cfg_index <= CFG_DIST_CMD;
    cfg_data  <= s.distance_command;
    @(posedge clk);
    cfg_index <= CFG_VER_CMD;
    cfg_data  <= s.version_command;
    @(posedge clk);
    cfg_index <= CFG_DIST_MINLEN;
    cfg_data  <= s.distance_min_length;
    @(posedge clk);
    cfg_index <= CFG_VER_MINLEN;
    cfg_data  <= s.version_min_length;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_shadow = s;
  endtask

  initial begin : stimulus
    rst            = 1'b1;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = 8'h00;
    cfg_we         = 1'b0;
    cfg_index      = CFG_PREAMBLE;
    cfg_data       = 8'h00;
    hold_off_start = 1'b0;
    sent_count     = 0;
    taken_count    = 0;
    fail_count     = 0;
    quiet_cycles   = 0;
    tx_gap_pct     = 37;
    rx_stall_pct   = 82;
    cfg_shadow     = '{RST_PREAMBLE, RST_DIST_CMD, RST_VER_CMD, RST_DIST_MINLEN,
                       RST_VER_MINLEN};
    pred_cmd       = 8'h00;
    pred_sum       = 8'h00;
    restart_hunt();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) send_row(DIRECTED[i]);
    quiesce();

    // The receiver holds off while a full-length distance frame streams in,
    // so the result register fills and the rx side has to stall.
    hold_off_start = 1'b1;
    send_frame(MAX_PAYLOAD, cfg_shadow.distance_command, 1'b1);
    run_phase(90);

    for (int p = 0; p < N_REG_SETS; p++) begin
      if (p == 1) begin
        tx_gap_pct   = 82;
        rx_stall_pct = 37;
      end else if (p == 3) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      load_settings(REG_SETS[p]);
      run_phase(130);
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
